// ===== design/mpo_pkg.sv =====
// Shared types, widths and constants of the multiwave phase oscillator.
`timescale 1ns / 1ps

package mpo_pkg;

    // Field and register widths
    localparam int FREQ_W      = 31;
    localparam int RATE_W      = 18;
    localparam int WAVE_W      = 2;
    localparam int CFG_DATA_W  = 18;
    localparam int CFG_INDEX_W = 1;

    // Sine datapath: Q30 operands, one shared 31x31 multiplier
    localparam int Q30         = 30;
    localparam int MUL_W       = 31;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int F32_W       = 32;
    localparam int SINE_STEPS  = 8;
    localparam int SINE_CYC    = 2 * SINE_STEPS;
    localparam int STEP_W      = 5;
    localparam logic [MUL_W-1:0] Q30_ONE = 31'h4000_0000;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM    = 1'b1;

    // Reset values
    localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

    // Waveform codes; anything else plays the triangle
    localparam logic [WAVE_W-1:0] WAVE_SINE = 2'd0;
    localparam logic [WAVE_W-1:0] WAVE_SAW  = 2'd1;
    localparam logic [WAVE_W-1:0] WAVE_TRI  = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    // Taylor coefficients of sin(pi/2 * x) in Q30, by power index
    function automatic logic [MUL_W-1:0] sine_coef(input logic [2:0] k);
        logic [MUL_W-1:0] c;
        case (k)
            3'd0:    c = 31'd1686629713;
            3'd1:    c = 31'd693598668;
            3'd2:    c = 31'd85569306;
            3'd3:    c = 31'd5026995;
            3'd4:    c = 31'd172272;
            3'd5:    c = 31'd3864;
            3'd6:    c = 31'd61;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== design/mpo_if.sv =====
// Handshake channels of the oscillator: frequency items in, sample items out.
`timescale 1ns / 1ps

interface mpo_freq_if;
    logic                        valid;
    logic                        ready;
    logic [mpo_pkg::FREQ_W-1:0]  frequency;

    modport source (output valid, output frequency, input ready);
    modport sink   (input valid, input frequency, output ready);
endinterface

interface mpo_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== design/multiwave_phase_oscillator_core.sv =====
// Top level of the multiwave phase oscillator: sequencer, sine unit and phase.
`timescale 1ns / 1ps

// Each frequency item (unsigned Q15.16 Hz) is one sample tick: the block
// returns one signed Q1.(SAMPLE_BITS-1) sample of sine, sawtooth or
// triangle taken from the phase before the tick, then advances the phase by
// frequency * 2^(PHASE_BITS-16) / sample_rate. The bit-serial divider forms the
// increment while the sine polynomial runs alongside it on one shared multiplier;
// the sample is registered once both are done. The next item is taken once the
// sample has been read. Writing either register clears the phase; write
// registers only while no item is in flight.
module multiwave_phase_oscillator_core #(
    parameter int PHASE_BITS  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mpo_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mpo_pkg::CFG_DATA_W-1:0]     cfg_data,
    mpo_freq_if.sink                           freq_ch,
    mpo_sample_if.source                       sample_ch
);

    localparam int SW = SAMPLE_BITS + 2;
    localparam logic signed [SW-1:0] HALF       = SW'(1) << (SAMPLE_BITS - 1);
    localparam logic signed [SW-1:0] TOP        = HALF - SW'(1);
    localparam logic signed [SW-1:0] THREE_HALF = SW'(3) << (SAMPLE_BITS - 1);
    localparam logic [31:0]          RND        = 32'd1 << (30 - SAMPLE_BITS);

    mpo_pkg::state_t state_reg;
    mpo_pkg::state_t state_next;

    logic [mpo_pkg::RATE_W-1:0]  rate_reg;
    logic [mpo_pkg::WAVE_W-1:0]  wave_reg;
    logic [PHASE_BITS-1:0]       phase_reg;
    logic                        in_acc;
    logic                        out_acc;
    logic                        finish;

    logic [mpo_pkg::F32_W-1:0]   f32;
    logic [SAMPLE_BITS-1:0]      u;
    logic signed [SW-1:0]        u_s;
    logic signed [SW-1:0]        saw_v;
    logic signed [SW-1:0]        tri_v;
    logic signed [SW-1:0]        sine_v;
    logic signed [SW-1:0]        wave_v;

    logic                        div_done;
    logic [PHASE_BITS-1:0]       div_quot;

    // Sine unit registers
    logic [mpo_pkg::STEP_W-1:0]  mstep_reg;
    logic [2:0]                  step;
    logic                        sine_done;
    logic [1:0]                  quad_reg;
    logic [mpo_pkg::MUL_W-1:0]   x_reg;
    logic [mpo_pkg::MUL_W-1:0]   x_init;
    logic [mpo_pkg::MUL_W-1:0]   x2_reg;
    logic [mpo_pkg::MUL_W-1:0]   s_reg;
    logic [mpo_pkg::MUL_W-1:0]   mag_reg;
    logic [mpo_pkg::MUL_W-1:0]   mul_a;
    logic [mpo_pkg::MUL_W-1:0]   mul_b;
    logic [mpo_pkg::PROD_W-1:0]  mul_prod;
    logic [mpo_pkg::PROD_W-1:0]  prod_reg;
    logic [mpo_pkg::MUL_W-1:0]   prod_hi;
    logic [31:0]                 rnd_sum;
    logic [SAMPLE_BITS:0]        sine_mag;
    logic signed [SW-1:0]        sine_sat;

    logic                        out_valid_reg;
    logic [SAMPLE_BITS-1:0]      sample_reg;

    // Handshakes
    assign in_acc          = freq_ch.valid & freq_ch.ready;
    assign out_acc         = sample_ch.valid & sample_ch.ready;
    assign freq_ch.ready   = (state_reg == mpo_pkg::S_IDLE) & ~out_valid_reg;
    assign sample_ch.valid = out_valid_reg;
    assign sample_ch.sample = sample_reg;
    assign finish          = (state_reg == mpo_pkg::S_RUN) & div_done & sine_done;

    // Phase scaled to 32 fraction bits
    generate
        if (PHASE_BITS >= 32)
        begin : g_phase_top
            assign f32 = phase_reg[PHASE_BITS-1 -: 32];
        end
        else
        begin : g_phase_pad
            assign f32 = {phase_reg, {(32 - PHASE_BITS){1'b0}}};
        end
    endgenerate

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mpo_pkg::S_IDLE: if (in_acc) state_next = mpo_pkg::S_RUN;
            mpo_pkg::S_RUN:  if (finish) state_next = mpo_pkg::S_IDLE;
            default:         state_next = mpo_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpo_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers and phase accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= mpo_pkg::RATE_RESET;
            wave_reg  <= mpo_pkg::WAVE_SINE;
            phase_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mpo_pkg::REG_SAMPLE_RATE: rate_reg <= cfg_data[mpo_pkg::RATE_W-1:0];
                mpo_pkg::REG_WAVEFORM:    wave_reg <= cfg_data[mpo_pkg::WAVE_W-1:0];
                default:                  ;
            endcase
            phase_reg <= '0;
        end
        else if (finish)
        begin
            phase_reg <= phase_reg + div_quot;
        end
    end

    // Increment divider, started with the item
    mpo_div #(
        .PHASE_BITS (PHASE_BITS)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_acc),
        .frequency   (freq_ch.frequency),
        .sample_rate (rate_reg),
        .done        (div_done),
        .quotient    (div_quot)
    );

    // Sine: x mirrored in odd quadrants
    assign x_init = f32[30] ? (mpo_pkg::Q30_ONE - {1'b0, f32[29:0]})
                            : {1'b0, f32[29:0]};

    // Step 0 squares x, steps 1..6 run Horner, step 7 scales by x;
    // even cycles multiply, odd cycles take the product
    assign step      = mstep_reg[3:1];
    assign sine_done = (mstep_reg == mpo_pkg::STEP_W'(mpo_pkg::SINE_CYC));
    assign prod_hi   = prod_reg[mpo_pkg::Q30 +: mpo_pkg::MUL_W];

    always_comb
    begin
        case (step)
            3'd0:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            3'd7:
            begin
                mul_a = x_reg;
                mul_b = s_reg;
            end
            default:
            begin
                mul_a = x2_reg;
                mul_b = s_reg;
            end
        endcase
    end

    assign mul_prod = mpo_pkg::PROD_W'(mul_a) * mpo_pkg::PROD_W'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mstep_reg <= mpo_pkg::STEP_W'(mpo_pkg::SINE_CYC);
        end
        else if (in_acc)
        begin
            mstep_reg <= '0;
        end
        else if (!sine_done)
        begin
            mstep_reg <= mstep_reg + mpo_pkg::STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg    <= x_init;
            s_reg    <= mpo_pkg::sine_coef(3'd6);
            quad_reg <= f32[31:30];
        end
        else if (!sine_done)
        begin
            if (!mstep_reg[0])
            begin
                prod_reg <= mul_prod;
            end
            else
            begin
                case (step)
                    3'd0:    x2_reg  <= prod_hi;
                    3'd7:    mag_reg <= prod_hi;
                    default: s_reg   <= mpo_pkg::sine_coef(3'(3'd6 - step)) - prod_hi;
                endcase
            end
        end
    end

    // Sine rounding, saturation and sign
    assign rnd_sum  = 32'(mag_reg) + RND;
    assign sine_mag = (SAMPLE_BITS + 1)'(rnd_sum >> (31 - SAMPLE_BITS));
    assign sine_sat = (signed'(SW'(sine_mag)) > TOP) ? TOP : signed'(SW'(sine_mag));
    assign sine_v   = quad_reg[1] ? -sine_sat : sine_sat;

    // Sawtooth and triangle from the top sample bits of the phase
    assign u     = f32[31 -: SAMPLE_BITS];
    assign u_s   = signed'(SW'(u));
    assign saw_v = ((HALF - u_s) > TOP) ? TOP : (HALF - u_s);

    always_comb
    begin
        if (u_s < HALF)
        begin
            tri_v = (u_s <<< 1) - HALF;
        end
        else if ((THREE_HALF - (u_s <<< 1)) > TOP)
        begin
            tri_v = TOP;
        end
        else
        begin
            tri_v = THREE_HALF - (u_s <<< 1);
        end
    end

    always_comb
    begin
        case (wave_reg)
            mpo_pkg::WAVE_SINE: wave_v = sine_v;
            mpo_pkg::WAVE_SAW:  wave_v = saw_v;
            mpo_pkg::WAVE_TRI:  wave_v = tri_v;
            default:            wave_v = tri_v;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_acc)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            sample_reg <= wave_v[SAMPLE_BITS-1:0];
        end
    end

endmodule

// ===== design/mpo_div.sv =====
// Bit-serial restoring divider for the phase increment.
`timescale 1ns / 1ps

module mpo_div #(
    parameter int PHASE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mpo_pkg::FREQ_W-1:0]    frequency,
    input  logic [mpo_pkg::RATE_W-1:0]    sample_rate,
    output logic                          done,
    output logic [PHASE_BITS-1:0]         quotient
);

    localparam int DW = PHASE_BITS + 15;
    localparam int CW = $clog2(DW + 1);
    localparam int RW = mpo_pkg::RATE_W;

    logic [CW-1:0]         cnt_reg;
    logic [RW-1:0]         rem_reg;
    logic [RW-1:0]         rem_next;
    logic [DW-1:0]         dvd_reg;
    logic [PHASE_BITS-1:0] quo_reg;
    logic [RW-1:0]         rate_reg;
    logic [RW:0]           trial;
    logic [RW:0]           diff;
    logic                  fits;

    // One quotient bit per cycle
    assign trial    = {rem_reg, dvd_reg[DW-1]};
    assign diff     = trial - {1'b0, rate_reg};
    assign fits     = (trial >= {1'b0, rate_reg});
    assign rem_next = fits ? diff[RW-1:0] : trial[RW-1:0];

    assign done     = (cnt_reg == CW'(DW));
    // A zero rate gives a zero increment
    assign quotient = (rate_reg == '0) ? '0 : quo_reg;

    // Bit counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CW'(DW);
        end
        else if (start)
        begin
            cnt_reg <= '0;
        end
        else if (!done)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    // Remainder, dividend and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            dvd_reg  <= DW'(frequency) << (PHASE_BITS - 16);
            quo_reg  <= '0;
            rate_reg <= sample_rate;
        end
        else if (!done)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            quo_reg <= {quo_reg[PHASE_BITS-2:0], fits};
        end
    end

endmodule

// ===== design/mpo_checker.sv =====
// Port-level checks of the oscillator and their binding to the top level.
`timescale 1ns / 1ps

module mpo_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   freq_valid,
    input logic                   freq_ready,
    input logic                   sample_valid,
    input logic                   sample_ready,
    input logic [SAMPLE_BITS-1:0] sample
);

    // Busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (freq_valid && freq_ready) |=> !freq_ready)
        else $error("input ready right after an item was taken");

    // No new item while a sample waits
    a_one_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid |-> !freq_ready)
        else $error("input ready while a sample is pending");

    // A sample never shows in the cycle after its item
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (freq_valid && freq_ready) |=> !sample_valid)
        else $error("sample appeared too early");

    // Stalled sample holds
    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_ready) |=> (sample_valid && $stable(sample)))
        else $error("stalled sample dropped or changed");

endmodule

bind multiwave_phase_oscillator_core mpo_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mpo_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .freq_valid   (freq_ch.valid),
    .freq_ready   (freq_ch.ready),
    .sample_valid (sample_ch.valid),
    .sample_ready (sample_ch.ready),
    .sample       (sample_ch.sample)
);

// ===== bench/multiwave_phase_oscillator_core_test.sv =====
// Self-checking bench for the oscillator core: predicted samples, random stalls.
`timescale 1ns / 1ps

module multiwave_phase_oscillator_core_test;

    // Code 3 has no name in the package; the core plays it as a triangle
    localparam logic [mpo_pkg::WAVE_W-1:0] WAVE_UNUSED = 2'd3;

    localparam int ITEM_LATENCY = 64;
    localparam int SEGMENTS     = 15;
    localparam int SEG_ITEMS    = 110;

    // sin(pi/2 * x) Taylor terms in Q30, lowest power first
    localparam longint unsigned SINE_TAYLOR [0:6] = '{
        64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
        64'd172272, 64'd3864, 64'd61
    };

    // Tracks rate, waveform and phase; holds the samples still owed by the core
    class sample_scoreboard;
        bit [mpo_pkg::RATE_W-1:0]   rate;
        bit [mpo_pkg::WAVE_W-1:0]   wave;
        bit [31:0]                  phase;
        bit signed [15:0]           owed_samples [$];
        int                         errors;

        function new();
            rate   = mpo_pkg::RATE_RESET;
            wave   = mpo_pkg::WAVE_SINE;
            phase  = '0;
            errors = 0;
        endfunction

        function int pending();
            return owed_samples.size();
        endfunction

        // Any register write also restarts the period
        function void write_reg(logic [mpo_pkg::CFG_INDEX_W-1:0] index,
                                logic [mpo_pkg::CFG_DATA_W-1:0] data);
            if (index == mpo_pkg::REG_SAMPLE_RATE)
                rate = data[mpo_pkg::RATE_W-1:0];
            else
                wave = data[mpo_pkg::WAVE_W-1:0];
            phase = '0;
        endfunction

        function bit signed [15:0] sine_of(bit [31:0] ph);
            bit [63:0] x;
            bit [63:0] x2;
            bit [63:0] s;
            bit [63:0] mag;
            x = {34'd0, ph[29:0]};
            // odd quadrants run the quarter wave backwards
            if (ph[30])
                x = (64'd1 << 30) - x;
            x2 = (x * x) >> 30;
            s = SINE_TAYLOR[6];
            for (int k = 5; k >= 0; k--)
                s = SINE_TAYLOR[k] - ((x2 * s) >> 30);
            mag = (x * s) >> 30;
            mag = (mag + (64'd1 << 14)) >> 15;
            if (mag > 64'd32767)
                mag = 64'd32767;
            return ph[31] ? -mag[15:0] : mag[15:0];
        endfunction

        function bit signed [15:0] shape_of(bit [31:0] ph);
            int u;
            int v;
            u = int'(ph[31:16]);
            if (wave == mpo_pkg::WAVE_SINE)
                return sine_of(ph);
            if (wave == mpo_pkg::WAVE_SAW)
                v = 32768 - u;
            else if (u < 32768)
                v = 2 * u - 32768;
            else
                v = 3 * 32768 - 2 * u;
            // +1.0 is out of range for Q1.15
            if (v > 32767)
                v = 32767;
            return v[15:0];
        endfunction

        // Sample comes from the phase before the tick, then the phase steps
        function void note_frequency(logic [mpo_pkg::FREQ_W-1:0] freq);
            bit [63:0] step;
            owed_samples.push_back(shape_of(phase));
            step = '0;
            if (rate != 0)
                step = ({33'd0, freq} << 16) / rate;
            phase = phase + step[31:0];
        endfunction

        function void check_sample(logic signed [15:0] actual);
            bit signed [15:0] want;
            if (owed_samples.size() == 0) begin
                $display("%0t: unexpected sample, expected none, actual %0d", $time, actual);
                errors++;
                return;
            end
            want = owed_samples.pop_front();
            if (actual !== want) begin
                $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, actual);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [mpo_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mpo_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                              send_idle;
    int                              recv_idle;
    sample_scoreboard                sb;

    mpo_freq_if                          freq_ch ();
    mpo_sample_if #(.SAMPLE_BITS(16))    sample_ch ();

    multiwave_phase_oscillator_core #(
        .PHASE_BITS  (32),
        .SAMPLE_BITS (16)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .freq_ch   (freq_ch),
        .sample_ch (sample_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // Sample consumer: random back-pressure
    initial
    begin
        sample_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            sample_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watch register writes and both channels at the sampling edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (sample_ch.valid && sample_ch.ready)
                sb.check_sample(sample_ch.sample);
            if (freq_ch.valid && freq_ch.ready)
                sb.note_frequency(freq_ch.frequency);
        end
    end

    // Present one frequency item after random idle cycles; returns on a falling edge
    task automatic send_freq(input logic [mpo_pkg::FREQ_W-1:0] freq);
        while ($urandom_range(99) < send_idle)
        begin
            freq_ch.valid <= 1'b0;
            @(negedge clk);
        end
        freq_ch.valid     <= 1'b1;
        freq_ch.frequency <= freq;
        do @(posedge clk); while (!freq_ch.ready);
        @(negedge clk);
    endtask

    // Hold off until every owed sample has come back
    task automatic wait_for_results();
        freq_ch.valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    // Both registers, written while the core is idle
    task automatic set_mode(input logic [mpo_pkg::RATE_W-1:0] rate,
                            input logic [mpo_pkg::WAVE_W-1:0] wave);
        logic [mpo_pkg::CFG_DATA_W-mpo_pkg::WAVE_W-1:0] junk;
        junk = (mpo_pkg::CFG_DATA_W - mpo_pkg::WAVE_W)'($urandom);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= mpo_pkg::REG_SAMPLE_RATE;
        cfg_data  <= rate;
        @(negedge clk);
        // upper bits of the waveform word must be ignored
        cfg_index <= mpo_pkg::REG_WAVEFORM;
        cfg_data  <= {junk, wave};
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [mpo_pkg::FREQ_W-1:0] random_frequency();
        logic [31:0] r;
        case ($urandom_range(3))
            0:       r = $urandom;
            3:       r = 32'h7FFF_FFFF - $urandom_range(0, 65535);
            default: r = $urandom_range(0, 32'd20000 << 16);
        endcase
        return r[mpo_pkg::FREQ_W-1:0];
    endfunction

    function automatic logic [mpo_pkg::RATE_W-1:0] random_rate();
        case ($urandom_range(9))
            0:       return 18'd1;
            1:       return 18'd192000;
            2:       return 18'd0;
            3:       return 18'h3FFFF;
            4:       return 18'd44100;
            5:       return 18'd48000;
            6:       return 18'd96000;
            default: return mpo_pkg::RATE_W'($urandom_range(1, 18'h3FFFF));
        endcase
    endfunction

    initial
    begin
        sb                = new();
        send_idle         = 10;
        recv_idle         = 52;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = mpo_pkg::REG_SAMPLE_RATE;
        cfg_data          = '0;
        freq_ch.valid     = 1'b0;
        freq_ch.frequency = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting: 12 kHz at 48 kHz lands on each quadrant boundary
        repeat (5) send_freq(31'd12000 << 16);
        send_freq('0);
        send_freq(31'h7FFF_FFFF);
        send_freq(31'd1);

        // Zero sample rate: phase must not move
        set_mode(18'd0, mpo_pkg::WAVE_SINE);
        repeat (2) send_freq(31'h7FFF_FFFF);

        // Saw in quarter steps, including the +1.0 clip at phase zero
        set_mode(18'd4, mpo_pkg::WAVE_SAW);
        repeat (5) send_freq(31'd1 << 16);

        // Spare code plays triangle; eighth steps hit the peak clip
        set_mode(18'd8, WAVE_UNUSED);
        repeat (5) send_freq(31'd1 << 16);

        set_mode(18'h3FFFF, mpo_pkg::WAVE_TRI);
        repeat (2) send_freq(31'h7FFF_FFFF);

        set_mode(18'd1, mpo_pkg::WAVE_SINE);
        repeat (2) send_freq(31'd1);

        // Random segments, each with its own setting
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg == SEGMENTS / 3)
            begin
                send_idle = 52;
                recv_idle = 10;
            end
            else if (seg == 2 * SEGMENTS / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            set_mode(random_rate(), mpo_pkg::WAVE_W'($urandom_range(3)));
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                if ($urandom_range(63) == 0)
                    wait_for_results();
                send_freq(random_frequency());
            end
        end

        wait_for_results();
        repeat (ITEM_LATENCY) @(negedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
